### hdl/npk_pkg.sv
// shared constants, coefficient tables and types for the npk compensation block
package npk_pkg;

    localparam int COEF_FRAC_BITS_DEF = 16;

    localparam int NPK_NUTS  = 3;
    localparam int NPK_SOILS = 5;

    // soil code used for codes above the table
    localparam logic [2:0] SOIL_LOAM = 3'd1;

    // growing condition code that adds the offsets
    localparam logic [1:0] GROW_GREENHOUSE = 2'd1;

    // config register indexes
    typedef enum logic [1:0] {
        CFG_SOIL_TYPE    = 2'd0,
        CFG_GROWING_COND = 2'd1
    } npk_cfg_idx_t;

    // temperature coefficients in 1e-4 per degC, [soil][n, p, k]
    localparam int unsigned KT_UNITS [NPK_SOILS][NPK_NUTS] = '{
        '{41, 53, 32}, '{38, 49, 29}, '{28, 35, 21}, '{32, 42, 24}, '{40, 51, 31}
    };

    // moisture coefficients in 0.01, [soil][n, p, k]
    localparam int unsigned KH_UNITS [NPK_SOILS][NPK_NUTS] = '{
        '{5, 6, 4}, '{4, 5, 3}, '{6, 7, 5}, '{3, 4, 2}, '{5, 6, 4}
    };

    // greenhouse offsets in mg/kg, n, p, k
    localparam int unsigned GH_ADD [NPK_NUTS] = '{200, 100, 150};

    // stage load enables, one per pipeline stage
    typedef struct packed {
        logic a;
        logic b;
        logic c;
        logic d;
        logic e;
        logic f;
    } npk_adv_t;

    // kt in q.f, halves rounded up
    function automatic logic [63:0] kt_q(input int unsigned units, input int unsigned f);
        return ((64'(units) << f) + 64'd5000) / 64'd10000;
    endfunction

    // kh in q.f, halves rounded up
    function automatic logic [63:0] kh_q(input int unsigned units, input int unsigned f);
        return ((64'(units) << f) + 64'd50) / 64'd100;
    endfunction

endpackage

### hdl/npk_lane.sv
// one nutrient's datapath: coefficient pick, factor build, two scalings, offset and clamp
module npk_lane #(
    parameter int COEF_FRAC_BITS = npk_pkg::COEF_FRAC_BITS_DEF,
    parameter int NUT            = 0
) (
    input  logic             aclk,
    input  npk_pkg::npk_adv_t adv,
    input  logic [2:0]       soil_sel,   // already mapped into 0..4
    input  logic [15:0]      raw_in,
    input  logic             dneg_a,     // stage a: temperature below 25 degC
    input  logic [9:0]       dabs_a,     // stage a: |t - 250|
    input  logic [8:0]       m_a,        // stage a: clamped moisture offset
    input  logic             applied_e,  // stage e flags
    input  logic             gh_e,
    output logic [15:0]      value_out
);
    import npk_pkg::*;

    localparam int F      = COEF_FRAC_BITS;
    localparam int KTQ_W  = F - 6;
    localparam int KHQ_W  = F - 3;
    localparam int TX_W   = F + 4;
    localparam int HY_W   = F + 5;
    localparam int TF_W   = F + 1;
    localparam int HQ_W   = F - 3;
    localparam int S_W    = F + 11;
    localparam int P_W    = 2 * F + 12;
    localparam int SF_W   = 16 + TF_W;
    localparam int V_W    = P_W + 1 - 2 * F;

    // reciprocal multipliers: exact floor division for TX_W / HY_W bit numerators
    localparam int K10    = TX_W + 4;
    localparam int M10_W  = F + 5;
    localparam int K350   = HY_W + 9;
    localparam int M350_W = F + 6;
    localparam logic [63:0] M10_FULL  = ((64'd1 << K10) + 64'd9) / 64'd10;
    localparam logic [63:0] M350_FULL = ((64'd1 << K350) + 64'd349) / 64'd350;
    localparam logic [M10_W-1:0]  M10  = M10_FULL[M10_W-1:0];
    localparam logic [M350_W-1:0] M350 = M350_FULL[M350_W-1:0];

    localparam logic [TX_W-1:0] TX_BIAS = TX_W'((64'd10 << F) + 64'd5);
    localparam logic [HY_W-1:0] HY_BIAS = HY_W'(175);
    localparam logic [TF_W-1:0] ONE_Q   = {1'b1, {F{1'b0}}};
    localparam logic [S_W-1:0]  S_MAX   = S_W'(64'd2000 << F);
    localparam logic [P_W:0]    HALF_Q  = (P_W + 1)'(1) << (2 * F - 1);
    localparam logic [V_W-1:0]  OFFS    = V_W'(GH_ADD[NUT]);
    localparam logic [V_W-1:0]  V_MAX   = V_W'(2000);

    logic [KTQ_W-1:0] ktq_tab [NPK_SOILS];
    logic [KHQ_W-1:0] khq_tab [NPK_SOILS];

    for (genvar g = 0; g < NPK_SOILS; g++) begin : g_coef
        assign ktq_tab[g] = KTQ_W'(kt_q(KT_UNITS[g][NUT], F));
        assign khq_tab[g] = KHQ_W'(kh_q(KH_UNITS[g][NUT], F));
    end

    // stage a
    logic [15:0]      raw_a_reg;
    logic [KTQ_W-1:0] ktq_a_reg;
    logic [KHQ_W-1:0] khq_a_reg;
    // stage b
    logic [15:0]      raw_b_reg;
    logic [TX_W-1:0]  tx_b_reg;
    logic [HY_W-1:0]  hy_b_reg;
    // stage c
    logic [15:0]      raw_c_reg;
    logic [TF_W-1:0]  tf_c_reg;
    logic [TF_W-1:0]  hf_c_reg;
    // stage d
    logic [15:0]      raw_d_reg;
    logic [S_W-1:0]   s_d_reg;
    logic [TF_W-1:0]  hf_d_reg;
    // stage e
    logic [15:0]      raw_e_reg;
    logic [P_W-1:0]   p_e_reg;
    // stage f
    logic [15:0]      value_f_reg;

    logic [TX_W-1:0]         kt_prod;
    logic [KHQ_W+8:0]        kh_full;
    logic [TX_W-1:0]         tx_next;
    logic [HY_W-1:0]         hy_next;
    logic [TX_W+M10_W-1:0]   tq_full;
    logic [HY_W+M350_W-1:0]  hq_full;
    logic [TF_W-1:0]         hf_next;
    logic [SF_W-1:0]         s_full;
    logic [S_W-1:0]          s_next;
    logic [P_W-1:0]          p_next;
    logic [P_W:0]            p_round;
    logic [V_W-1:0]          v_scaled;
    logic [V_W-1:0]          v_off;
    logic [V_W-1:0]          v_clamp;
    logic [15:0]             value_next;

    assign kt_prod = TX_W'(ktq_a_reg) * TX_W'(dabs_a);
    assign tx_next = dneg_a ? (TX_BIAS + kt_prod) : (TX_BIAS - kt_prod);
    assign kh_full = (KHQ_W + 9)'(khq_a_reg) * (KHQ_W + 9)'(m_a);
    assign hy_next = kh_full[HY_W-1:0] + HY_BIAS;

    assign tq_full = (TX_W + M10_W)'(tx_b_reg) * (TX_W + M10_W)'(M10);
    assign hq_full = (HY_W + M350_W)'(hy_b_reg) * (HY_W + M350_W)'(M350);
    assign hf_next = ONE_Q + TF_W'(hq_full[K350 +: HQ_W]);

    // saturation leaves the result unchanged since hf >= 1 and offsets are >= 0
    assign s_full = SF_W'(raw_c_reg) * SF_W'(tf_c_reg);
    assign s_next = (s_full > SF_W'(S_MAX)) ? S_MAX : s_full[S_W-1:0];

    assign p_next = P_W'(s_d_reg) * P_W'(hf_d_reg);

    assign p_round  = (P_W + 1)'(p_e_reg) + HALF_Q;
    assign v_scaled = p_round[P_W -: V_W];
    assign v_off    = gh_e ? (v_scaled + OFFS) : v_scaled;
    assign v_clamp  = (v_off > V_MAX) ? V_MAX : v_off;
    assign value_next = applied_e ? 16'(v_clamp) : raw_e_reg;

    always_ff @(posedge aclk) begin
        if (adv.a) begin
            raw_a_reg <= raw_in;
            ktq_a_reg <= ktq_tab[soil_sel];
            khq_a_reg <= khq_tab[soil_sel];
        end
        if (adv.b) begin
            raw_b_reg <= raw_a_reg;
            tx_b_reg  <= tx_next;
            hy_b_reg  <= hy_next;
        end
        if (adv.c) begin
            raw_c_reg <= raw_b_reg;
            tf_c_reg  <= tq_full[K10 +: TF_W];
            hf_c_reg  <= hf_next;
        end
        if (adv.d) begin
            raw_d_reg <= raw_c_reg;
            s_d_reg   <= s_next;
            hf_d_reg  <= hf_c_reg;
        end
        if (adv.e) begin
            raw_e_reg <= raw_d_reg;
            p_e_reg   <= p_next;
        end
        if (adv.f) begin
            value_f_reg <= value_next;
        end
    end

    assign value_out = value_f_reg;

endmodule

### hdl/npk_temperature_moisture_compensation.sv
// top level of the npk temperature and moisture compensation pipeline
//
//  channel   direction  handshake             payload
//  s_        in         s_tvalid / s_tready   s_tdata: temperature, moisture, n, p, k raw
//  m_        out        m_tvalid / m_tready   m_tdata: n, p, k out; m_tuser: applied
//  cfg_      in         cfg_valid / cfg_ready cfg_addr register index, cfg_wdata value
//
//  six register stages (a..f), one beat per cycle sustained while m_tready is high;
//  the stage count is set by the chain of wide multiplies per lane (coefficient
//  products, reciprocal division, raw * tf, s * hf), each followed by a register,
//  and a last stage for rounding, offset and clamp
//  each stage loads when it is empty or the stage after it loads, so bubbles close
//  up and a stalled output holds every beat in place
//  aresetn is synchronous: clears stage valids and sets soil_type to loam,
//  growing_condition to code 0 (not greenhouse); cfg_ready is always high
module npk_temperature_moisture_compensation #(
    parameter int COEF_FRAC_BITS = npk_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,    // temperature[11:0], moisture[22:12], nitrogen_raw[38:23],
                                    // phosphorus_raw[54:39], potassium_raw[70:55], zero[71]
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // nitrogen_out[15:0], phosphorus_out[31:16],
                                    // potassium_out[47:32]
    output logic        m_tuser,    // applied[0]
    // config writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_addr,
    input  logic [2:0]  cfg_wdata
);
    import npk_pkg::*;

    // config registers
    logic [2:0] soil_type_reg;
    logic [1:0] growing_reg;

    // stage valids
    logic valid_a_reg, valid_b_reg, valid_c_reg, valid_d_reg, valid_e_reg, valid_f_reg;

    // per-beat flags traveling with the data
    logic applied_a_reg, applied_b_reg, applied_c_reg, applied_d_reg, applied_e_reg;
    logic applied_f_reg;
    logic gh_a_reg, gh_b_reg, gh_c_reg, gh_d_reg, gh_e_reg;

    // shared stage a terms
    logic       dneg_a_reg;
    logic [9:0] dabs_a_reg;
    logic [8:0] m_a_reg;

    npk_adv_t adv;

    logic signed [11:0] temp_in;
    logic [10:0]        moist_in;
    logic signed [12:0] dt;
    logic [12:0]        dt_mag;
    logic [10:0]        moist_off;
    logic [8:0]         m_next;
    logic               in_range;
    logic [2:0]         soil_sel;
    logic [15:0]        n_out, p_out, k_out;

    assign temp_in  = s_tdata[11:0];
    assign moist_in = s_tdata[22:12];

    // stage enables: a stage moves when empty or when the next one moves
    assign adv.f = !valid_f_reg || m_tready;
    assign adv.e = !valid_e_reg || adv.f;
    assign adv.d = !valid_d_reg || adv.e;
    assign adv.c = !valid_c_reg || adv.d;
    assign adv.b = !valid_b_reg || adv.c;
    assign adv.a = !valid_a_reg || adv.b;

    assign s_tready  = adv.a;
    assign cfg_ready = 1'b1;

    // out-of-range readings pass the raw values through
    assign in_range = (temp_in >= -12'sd500) && (temp_in <= 12'sd1000) &&
                      (moist_in >= 11'd10) && (moist_in <= 11'd1000);

    // temperature offset from 25 degC, sign and magnitude
    assign dt     = {temp_in[11], temp_in} - 13'sd250;
    assign dt_mag = dt[12] ? 13'(-dt) : 13'(dt);

    // moisture offset from 25 percent, clamped to 0..35 percent
    assign moist_off = moist_in - 11'd250;
    always_comb begin
        if (moist_in < 11'd250) begin
            m_next = 9'd0;
        end else if (moist_in > 11'd600) begin
            m_next = 9'd350;
        end else begin
            m_next = moist_off[8:0];
        end
    end

    // soil codes above the table (5 and up) use loam coefficients
    assign soil_sel = (soil_type_reg < 3'(NPK_SOILS)) ? soil_type_reg : SOIL_LOAM;

    // config write decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            soil_type_reg <= SOIL_LOAM;
            growing_reg   <= 2'd0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                CFG_SOIL_TYPE:    soil_type_reg <= cfg_wdata;
                CFG_GROWING_COND: growing_reg   <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
            valid_e_reg <= 1'b0;
            valid_f_reg <= 1'b0;
        end else begin
            if (adv.a) valid_a_reg <= s_tvalid;
            if (adv.b) valid_b_reg <= valid_a_reg;
            if (adv.c) valid_c_reg <= valid_b_reg;
            if (adv.d) valid_d_reg <= valid_c_reg;
            if (adv.e) valid_e_reg <= valid_d_reg;
            if (adv.f) valid_f_reg <= valid_e_reg;
        end
    end

    // flags and shared terms, no reset needed
    always_ff @(posedge aclk) begin
        if (adv.a) begin
            applied_a_reg <= in_range;
            gh_a_reg      <= (growing_reg == GROW_GREENHOUSE);
            dneg_a_reg    <= dt[12];
            dabs_a_reg    <= dt_mag[9:0];
            m_a_reg       <= m_next;
        end
        if (adv.b) begin
            applied_b_reg <= applied_a_reg;
            gh_b_reg      <= gh_a_reg;
        end
        if (adv.c) begin
            applied_c_reg <= applied_b_reg;
            gh_c_reg      <= gh_b_reg;
        end
        if (adv.d) begin
            applied_d_reg <= applied_c_reg;
            gh_d_reg      <= gh_c_reg;
        end
        if (adv.e) begin
            applied_e_reg <= applied_d_reg;
            gh_e_reg      <= gh_d_reg;
        end
        if (adv.f) begin
            applied_f_reg <= applied_e_reg;
        end
    end

    // one lane per nutrient
    npk_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .NUT(0)) u_lane_n (
        .aclk      (aclk),
        .adv       (adv),
        .soil_sel  (soil_sel),
        .raw_in    (s_tdata[38:23]),
        .dneg_a    (dneg_a_reg),
        .dabs_a    (dabs_a_reg),
        .m_a       (m_a_reg),
        .applied_e (applied_e_reg),
        .gh_e      (gh_e_reg),
        .value_out (n_out)
    );

    npk_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .NUT(1)) u_lane_p (
        .aclk      (aclk),
        .adv       (adv),
        .soil_sel  (soil_sel),
        .raw_in    (s_tdata[54:39]),
        .dneg_a    (dneg_a_reg),
        .dabs_a    (dabs_a_reg),
        .m_a       (m_a_reg),
        .applied_e (applied_e_reg),
        .gh_e      (gh_e_reg),
        .value_out (p_out)
    );

    npk_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .NUT(2)) u_lane_k (
        .aclk      (aclk),
        .adv       (adv),
        .soil_sel  (soil_sel),
        .raw_in    (s_tdata[70:55]),
        .dneg_a    (dneg_a_reg),
        .dabs_a    (dabs_a_reg),
        .m_a       (m_a_reg),
        .applied_e (applied_e_reg),
        .gh_e      (gh_e_reg),
        .value_out (k_out)
    );

    assign m_tvalid = valid_f_reg;
    assign m_tdata  = {k_out, p_out, n_out};
    assign m_tuser  = applied_f_reg;

`ifndef SYNTHESIS
    // a compensated beat never leaves the 0..2000 range
    a_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |->
            (n_out <= 16'd2000) && (p_out <= 16'd2000) && (k_out <= 16'd2000))
        else $error("compensated value above 2000");

    // an accepted input beat lands in stage a
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> valid_a_reg)
        else $error("accepted beat not captured");

    // a full pipeline behind a stalled output takes nothing in
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_a_reg && valid_b_reg && valid_c_reg && valid_d_reg && valid_e_reg &&
         m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while pipeline full");

    // a beat in stage e reaches the output when it moves
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_e_reg && adv.f) |=> m_tvalid)
        else $error("stage e beat lost");

    // reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");
`endif

endmodule
